// File: hdl/qpt_pkg.sv
package qpt_pkg;

   localparam int QUAT_BITS              = 32;
   localparam int COORD_WIDTH_DEFAULT    = 32;
   localparam int QUAT_FRAC_BITS_DEFAULT = 30;
   localparam int CSR_INDEX_BITS         = 3;

   // cycles from a quaternion register update to settled matrix coefficients
   localparam int MATRIX_LATENCY = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_X  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_Y  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_Z  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUAT_W  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHIFT_X = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHIFT_Y = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHIFT_Z = 3'd6;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] x;
      logic signed [QUAT_BITS-1:0] y;
      logic signed [QUAT_BITS-1:0] z;
      logic signed [QUAT_BITS-1:0] w;
   } quat_type;

   // rounded pairwise product: (2*QUAT_BITS+1) - frac bits; coefficient adds 3 bits
   function automatic int coef_width(input int frac_bits);
      return 2 * QUAT_BITS + 4 - frac_bits;
   endfunction

   // three products plus translation and rounding constant
   function automatic int sum_width(input int coord_width, input int frac_bits);
      return coef_width(frac_bits) + coord_width + 2;
   endfunction

endpackage

// File: hdl/qpt_matrix.sv
module qpt_matrix #(
   parameter int QUAT_FRAC_BITS = qpt_pkg::QUAT_FRAC_BITS_DEFAULT
) (
   input  logic                                                  clock,
   input  qpt_pkg::quat_type                                     quat,
   output logic signed [qpt_pkg::coef_width(QUAT_FRAC_BITS)-1:0] coef [9]
);

   localparam int QB     = qpt_pkg::QUAT_BITS;
   localparam int PW     = 2 * QB;
   localparam int RP_W   = PW + 1 - QUAT_FRAC_BITS;
   localparam int COEF_W = qpt_pkg::coef_width(QUAT_FRAC_BITS);
   localparam logic signed [PW:0]       HALF = (PW + 1)'(1) << (QUAT_FRAC_BITS - 1);
   localparam logic signed [COEF_W-1:0] ONE  = COEF_W'(1) << QUAT_FRAC_BITS;

   logic signed [QB-1:0]     qx, qy, qz, qw;
   logic signed [PW-1:0]     prod_in [9];
   logic signed [PW-1:0]     prod_ff [9];
   logic signed [RP_W-1:0]   rnd [9];
   logic signed [COEF_W-1:0] e [9];
   logic signed [COEF_W-1:0] coef_in [9];
   logic signed [COEF_W-1:0] coef_ff [9];
   logic signed [PW:0]       biased [9];

   assign qx = quat.x;
   assign qy = quat.y;
   assign qz = quat.z;
   assign qw = quat.w;

   // order: xx xy xz xw yy yz yw zz zw
   assign prod_in[0] = qx * qx;
   assign prod_in[1] = qx * qy;
   assign prod_in[2] = qx * qz;
   assign prod_in[3] = qx * qw;
   assign prod_in[4] = qy * qy;
   assign prod_in[5] = qy * qz;
   assign prod_in[6] = qy * qw;
   assign prod_in[7] = qz * qz;
   assign prod_in[8] = qz * qw;

   // free running: the registers load on every clock, with no enable
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      coef_ff <= coef_in;
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         biased[k] = {prod_ff[k][PW-1], prod_ff[k]} + HALF;
         rnd[k]    = RP_W'(biased[k] >>> QUAT_FRAC_BITS);
         e[k]      = {{(COEF_W - RP_W){rnd[k][RP_W-1]}}, rnd[k]};
      end
      coef_in[0] = ONE - ((e[4] + e[7]) <<< 1);
      coef_in[1] = (e[1] - e[8]) <<< 1;
      coef_in[2] = (e[2] + e[6]) <<< 1;
      coef_in[3] = (e[1] + e[8]) <<< 1;
      coef_in[4] = ONE - ((e[0] + e[7]) <<< 1);
      coef_in[5] = (e[5] - e[3]) <<< 1;
      coef_in[6] = (e[2] - e[6]) <<< 1;
      coef_in[7] = (e[5] + e[3]) <<< 1;
      coef_in[8] = ONE - ((e[0] + e[4]) <<< 1);
   end

   assign coef = coef_ff;

endmodule

// File: hdl/qpt_mac.sv
module qpt_mac #(
   parameter int COORD_WIDTH    = qpt_pkg::COORD_WIDTH_DEFAULT,
   parameter int QUAT_FRAC_BITS = qpt_pkg::QUAT_FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic                                   in_mode,
   input  logic signed [COORD_WIDTH-1:0]          in_coord [3],
   input  logic signed [qpt_pkg::coef_width(QUAT_FRAC_BITS)-1:0] coef [9],
   input  logic signed [COORD_WIDTH-1:0]          shift [3],
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [qpt_pkg::sum_width(COORD_WIDTH, QUAT_FRAC_BITS)-QUAT_FRAC_BITS-1:0]
                                                  out_value [3]
);

   localparam int COEF_W = qpt_pkg::coef_width(QUAT_FRAC_BITS);
   localparam int PROD_W = COEF_W + COORD_WIDTH;
   localparam int SUM_W  = qpt_pkg::sum_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam int R_W    = SUM_W - QUAT_FRAC_BITS;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (QUAT_FRAC_BITS - 1);

   logic va_ff, vb_ff, vc_ff;
   logic ra, rb, rc;
   logic mode_a_ff;

   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [SUM_W-1:0]  part0_in [3];
   logic signed [SUM_W-1:0]  part1_in [3];
   logic signed [SUM_W-1:0]  part0_ff [3];
   logic signed [SUM_W-1:0]  part1_ff [3];
   logic signed [SUM_W-1:0]  total [3];
   logic signed [SUM_W-1:0]  shift_term [3];
   logic signed [R_W-1:0]    value_in [3];
   logic signed [R_W-1:0]    value_ff [3];

   assign rc       = !vc_ff || out_ready;
   assign rb       = !vb_ff || rc;
   assign ra       = !va_ff || rb;
   assign in_ready = ra;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[3*i+j] = coef[3*i+j] * in_coord[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // point mode adds the translation scaled to the coefficient format
         shift_term[i] = mode_a_ff ? SUM_W'(0)
                       : ({{(SUM_W - COORD_WIDTH){shift[i][COORD_WIDTH-1]}}, shift[i]}
                          <<< QUAT_FRAC_BITS);
         part0_in[i] = {{2{prod_ff[3*i][PROD_W-1]}}, prod_ff[3*i]}
                     + {{2{prod_ff[3*i+1][PROD_W-1]}}, prod_ff[3*i+1]};
         part1_in[i] = {{2{prod_ff[3*i+2][PROD_W-1]}}, prod_ff[3*i+2]}
                     + shift_term[i] + HALF;
         total[i]    = part0_ff[i] + part1_ff[i];
         value_in[i] = R_W'(total[i] >>> QUAT_FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ra) begin
            va_ff <= in_valid;
         end
         if (rb) begin
            vb_ff <= va_ff;
         end
         if (rc) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ra) begin
         prod_ff   <= prod_in;
         mode_a_ff <= in_mode;
      end
      if (rb) begin
         part0_ff <= part0_in;
         part1_ff <= part1_in;
      end
      if (rc) begin
         value_ff <= value_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_value = value_ff;

endmodule

// File: hdl/qpt_sat.sv
module qpt_sat #(
   parameter int COORD_WIDTH    = qpt_pkg::COORD_WIDTH_DEFAULT,
   parameter int QUAT_FRAC_BITS = qpt_pkg::QUAT_FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [qpt_pkg::sum_width(COORD_WIDTH, QUAT_FRAC_BITS)-QUAT_FRAC_BITS-1:0]
                                         in_value [3],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_value [3],
   output logic                          out_saturated
);

   localparam int R_W = qpt_pkg::sum_width(COORD_WIDTH, QUAT_FRAC_BITS) - QUAT_FRAC_BITS;
   localparam logic signed [R_W-1:0] MAX_EXT =
      {{(R_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [R_W-1:0] MIN_EXT =
      {{(R_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] MAX_OUT = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] MIN_OUT = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   logic                          v_ff;
   logic                          load;
   logic signed [COORD_WIDTH-1:0] value_in [3];
   logic signed [COORD_WIDTH-1:0] value_ff [3];
   logic [2:0]                    clip;
   logic                          sat_in, sat_ff;

   assign load     = !v_ff || out_ready;
   assign in_ready = load;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         priority if (in_value[i] > MAX_EXT) begin
            value_in[i] = MAX_OUT;
            clip[i]     = 1'b1;
         end else if (in_value[i] < MIN_EXT) begin
            value_in[i] = MIN_OUT;
            clip[i]     = 1'b1;
         end else begin
            value_in[i] = in_value[i][COORD_WIDTH-1:0];
            clip[i]     = 1'b0;
         end
      end
      sat_in = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (load) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid     = v_ff;
   assign out_value     = value_ff;
   assign out_saturated = sat_ff;

endmodule

// File: hdl/quaternion_point_transform.sv
// Rigid pose (quaternion rotation plus translation) applied to a stream of
// 3D coordinates, one coordinate triple per transfer.
// req_*: input channel, valid/ready. req_mode 0 rotates and translates a point,
//   1 rotates a direction vector only. Coordinates are signed fixed point.
// rsp_*: result channel, valid/ready, one result per input, in order.
//   rsp_saturated flags that at least one component was clamped.
// csr_*: register writes, always ready. Index 0..3 quaternion x, y, z, w,
//   4..6 translation x, y, z; index 7 is ignored. Write only while no item
//   is in flight.
// Throughput: one item per cycle while rsp_ready stays high. Pipeline: three
//   skew stages let the matrix unit (two registered stages fed by the
//   quaternion registers) settle after a write, then product, partial-sum,
//   final-sum and clamp stages follow.
// Reset: pipeline emptied, quaternion set to identity, translation to zero.
// Stall: a stalled receiver fills the pipeline back to the input; bubbles are
//   squeezed out, so req_ready stays high until every stage holds an item.
module quaternion_point_transform #(
   parameter int COORD_WIDTH    = qpt_pkg::COORD_WIDTH_DEFAULT,
   parameter int QUAT_FRAC_BITS = qpt_pkg::QUAT_FRAC_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic                                       req_mode,
   input  logic signed [COORD_WIDTH-1:0]              req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]              req_coord_y,
   input  logic signed [COORD_WIDTH-1:0]              req_coord_z,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [COORD_WIDTH-1:0]              rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]              rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]              rsp_out_z,
   output logic                                       rsp_saturated,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [qpt_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [((COORD_WIDTH > qpt_pkg::QUAT_BITS) ? COORD_WIDTH
                  : qpt_pkg::QUAT_BITS)-1:0]          csr_data
);

   localparam int QB     = qpt_pkg::QUAT_BITS;
   localparam int COEF_W = qpt_pkg::coef_width(QUAT_FRAC_BITS);
   localparam int R_W    = qpt_pkg::sum_width(COORD_WIDTH, QUAT_FRAC_BITS) - QUAT_FRAC_BITS;
   localparam int SKEW   = qpt_pkg::MATRIX_LATENCY + 1;
   localparam logic signed [QB-1:0] QUAT_ONE = QB'(1) << QUAT_FRAC_BITS;

   qpt_pkg::quat_type             quat_ff;
   logic signed [COORD_WIDTH-1:0] shift_ff [3];
   logic                          csr_write;

   logic                          dv_ff [SKEW];
   logic                          dready [SKEW+1];
   logic                          dmode_ff [SKEW];
   logic signed [COORD_WIDTH-1:0] dcoord_ff [SKEW][3];

   logic signed [COEF_W-1:0]      coef [9];
   logic                          mac_in_ready;
   logic                          mac_out_valid;
   logic                          sat_in_ready;
   logic signed [R_W-1:0]         mac_value [3];
   logic signed [COORD_WIDTH-1:0] rsp_value [3];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.x   <= '0;
         quat_ff.y   <= '0;
         quat_ff.z   <= '0;
         quat_ff.w   <= QUAT_ONE;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            qpt_pkg::REG_QUAT_X:  quat_ff.x   <= csr_data[QB-1:0];
            qpt_pkg::REG_QUAT_Y:  quat_ff.y   <= csr_data[QB-1:0];
            qpt_pkg::REG_QUAT_Z:  quat_ff.z   <= csr_data[QB-1:0];
            qpt_pkg::REG_QUAT_W:  quat_ff.w   <= csr_data[QB-1:0];
            qpt_pkg::REG_SHIFT_X: shift_ff[0] <= csr_data[COORD_WIDTH-1:0];
            qpt_pkg::REG_SHIFT_Y: shift_ff[1] <= csr_data[COORD_WIDTH-1:0];
            qpt_pkg::REG_SHIFT_Z: shift_ff[2] <= csr_data[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   qpt_matrix #(
      .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
   ) u_matrix (
      .clock (clock),
      .quat  (quat_ff),
      .coef  (coef)
   );

   // skew stages: hold items until coefficients from a fresh write settle
   always_comb begin
      dready[SKEW] = mac_in_ready;
      for (int k = SKEW - 1; k >= 0; k--) begin
         dready[k] = !dv_ff[k] || dready[k+1];
      end
   end

   assign req_ready = dready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SKEW; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else begin
         if (dready[0]) begin
            dv_ff[0] <= req_valid;
         end
         for (int k = 1; k < SKEW; k++) begin
            if (dready[k]) begin
               dv_ff[k] <= dv_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dready[0]) begin
         dmode_ff[0]     <= req_mode;
         dcoord_ff[0][0] <= req_coord_x;
         dcoord_ff[0][1] <= req_coord_y;
         dcoord_ff[0][2] <= req_coord_z;
      end
      for (int k = 1; k < SKEW; k++) begin
         if (dready[k]) begin
            dmode_ff[k]  <= dmode_ff[k-1];
            dcoord_ff[k] <= dcoord_ff[k-1];
         end
      end
   end

   qpt_mac #(
      .COORD_WIDTH    (COORD_WIDTH),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_ff[SKEW-1]),
      .in_ready  (mac_in_ready),
      .in_mode   (dmode_ff[SKEW-1]),
      .in_coord  (dcoord_ff[SKEW-1]),
      .coef      (coef),
      .shift     (shift_ff),
      .out_valid (mac_out_valid),
      .out_ready (sat_in_ready),
      .out_value (mac_value)
   );

   qpt_sat #(
      .COORD_WIDTH    (COORD_WIDTH),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_sat (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mac_out_valid),
      .in_ready      (sat_in_ready),
      .in_value      (mac_value),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_value     (rsp_value),
      .out_saturated (rsp_saturated)
   );

   assign rsp_out_x = rsp_value[0];
   assign rsp_out_y = rsp_value[1];
   assign rsp_out_z = rsp_value[2];

endmodule
